// File: rtl/sbsw_pkg.sv
// ----------------------------------------------------------------------------
// Sync-write framer package
// Shared types, register indexes, protocol bytes and the byte-wise CRC step.
// ----------------------------------------------------------------------------
package sbsw_pkg;

   localparam int MAX_MOTORS = 16;
   localparam int CNT_W      = $clog2(MAX_MOTORS + 1);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   localparam logic [CSR_AW-1:0] CSR_PROTOCOL   = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_START_ADDR = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_DATA_LEN   = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_MOTOR_CNT  = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_VALUE_FMT  = 3'd4;

   localparam logic [7:0]  SYNC_BYTE        = 8'hFF;
   localparam logic [7:0]  LONG_MARK        = 8'hFD;
   localparam logic [7:0]  BCAST_ID         = 8'hFE;
   localparam logic [7:0]  INSTR_SYNC_WRITE = 8'h83;
   localparam logic [15:0] CRC_POLY         = 16'h8005;

   localparam logic signed [15:0] SPEED_MAX = 16'sd1023;
   localparam logic signed [15:0] SPEED_MIN = -16'sd1023;

   localparam logic [15:0] LONG_LEN_BASE  = 16'd7;
   localparam logic [15:0] SHORT_LEN_BASE = 16'd4;

   localparam int IDX_W = 4;
   localparam logic [IDX_W-1:0] HDR_LONG_LAST  = 4'd11;
   localparam logic [IDX_W-1:0] HDR_SHORT_LAST = 4'd6;

   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  motor_id;
      logic [31:0] value;
   } sbsw_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       packet_last;
   } sbsw_rsp_type;

   typedef struct packed {
      logic        open_pkt;
      logic        close_pkt;
      logic        proto;
      logic [2:0]  dlen;
      logic [15:0] addr;
      logic [15:0] len;
      logic [7:0]  motor_id;
      logic [31:0] value;
   } sbsw_cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR,
      PH_ID,
      PH_DATA,
      PH_TRL
   } sbsw_phase_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc_i, input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] hdr_byte(input logic proto, input logic [IDX_W-1:0] idx,
                                           input logic [15:0] len, input logic [15:0] addr,
                                           input logic [2:0] dlen);
      logic [7:0] b;
      b = 8'h00;
      if (proto) begin
         unique case (idx)
            4'd0, 4'd1: b = SYNC_BYTE;
            4'd2:       b = LONG_MARK;
            4'd3:       b = 8'h00;
            4'd4:       b = BCAST_ID;
            4'd5:       b = len[7:0];
            4'd6:       b = len[15:8];
            4'd7:       b = INSTR_SYNC_WRITE;
            4'd8:       b = addr[7:0];
            4'd9:       b = addr[15:8];
            4'd10:      b = {5'd0, dlen};
            default:    b = 8'h00;
         endcase
      end else begin
         unique case (idx)
            4'd0, 4'd1: b = SYNC_BYTE;
            4'd2:       b = BCAST_ID;
            4'd3:       b = len[7:0];
            4'd4:       b = INSTR_SYNC_WRITE;
            4'd5:       b = addr[7:0];
            4'd6:       b = {5'd0, dlen};
            default:    b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

// File: rtl/sbsw_front.sv
// ----------------------------------------------------------------------------
// Sync-write framer front end
// Holds the configuration registers, counts entries of the open packet,
// latches the packet settings on its first beat and builds one command.
// ----------------------------------------------------------------------------
module sbsw_front
   import sbsw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  sbsw_req_type      req_payload,
   input  logic              q_full,
   output logic              q_push,
   output sbsw_cmd_type      q_data
);

   logic             cfg_proto_ff;
   logic [15:0]      cfg_addr_ff;
   logic [2:0]       cfg_dlen_ff;
   logic [4:0]       cfg_count_ff;
   logic             cfg_fmt_ff;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             lat_proto_ff, lat_proto_in;
   logic [2:0]       lat_dlen_ff, lat_dlen_in;
   logic [CNT_W-1:0] lat_count_ff, lat_count_in;
   logic             lat_fmt_ff, lat_fmt_in;

   logic             opening;
   logic             closing;
   logic [2:0]       dlen_fresh;
   logic [CNT_W-1:0] count_fresh;
   logic [CNT_W:0]   cnt_next;
   logic [CNT_W+2:0] prod;
   logic [15:0]      len;
   logic signed [15:0] spd;
   logic [9:0]       mag;
   logic [31:0]      value_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_proto_ff <= 1'b1;
         cfg_addr_ff  <= 16'd116;
         cfg_dlen_ff  <= 3'd4;
         cfg_count_ff <= 5'd8;
         cfg_fmt_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PROTOCOL:   cfg_proto_ff <= csr_wdata[0];
            CSR_START_ADDR: cfg_addr_ff  <= csr_wdata;
            CSR_DATA_LEN:   cfg_dlen_ff  <= csr_wdata[2:0];
            CSR_MOTOR_CNT:  cfg_count_ff <= csr_wdata[4:0];
            CSR_VALUE_FMT:  cfg_fmt_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cfg_dlen_ff == 3'd0) begin
         dlen_fresh = 3'd1;
      end else if (cfg_dlen_ff > 3'd4) begin
         dlen_fresh = 3'd4;
      end else begin
         dlen_fresh = cfg_dlen_ff;
      end
      if (cfg_count_ff == 5'd0) begin
         count_fresh = CNT_W'(1);
      end else if (int'(cfg_count_ff) > MAX_MOTORS) begin
         count_fresh = CNT_W'(MAX_MOTORS);
      end else begin
         count_fresh = CNT_W'(cfg_count_ff);
      end
   end

   assign opening      = (cnt_ff == '0);
   assign lat_proto_in = opening ? cfg_proto_ff : lat_proto_ff;
   assign lat_dlen_in  = opening ? dlen_fresh : lat_dlen_ff;
   assign lat_count_in = opening ? count_fresh : lat_count_ff;
   assign lat_fmt_in   = opening ? cfg_fmt_ff : lat_fmt_ff;

   assign cnt_next = {1'b0, cnt_ff} + (CNT_W+1)'(1);
   assign closing  = (cnt_next >= {1'b0, lat_count_in});
   assign cnt_in   = closing ? '0 : cnt_next[CNT_W-1:0];

   assign prod = (CNT_W+3)'(lat_count_in) * (CNT_W+3)'({1'b0, lat_dlen_in} + 4'd1);
   assign len  = (lat_proto_in ? LONG_LEN_BASE : SHORT_LEN_BASE) + 16'(prod);

   // Speed format: clamp to the symmetric range and send the sign above the magnitude.
   assign spd = signed'(req_payload.value[15:0]);
   always_comb begin
      if (spd > SPEED_MAX) begin
         mag = 10'd1023;
      end else if (spd < SPEED_MIN) begin
         mag = 10'd1023;
      end else if (spd[15]) begin
         mag = 10'(-spd);
      end else begin
         mag = spd[9:0];
      end
   end
   assign value_out = lat_fmt_in ? {21'd0, spd[15], mag} : req_payload.value;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_data.open_pkt  = opening;
      q_data.close_pkt = closing;
      q_data.proto     = lat_proto_in;
      q_data.dlen      = lat_dlen_in;
      q_data.addr      = cfg_addr_ff;
      q_data.len       = len;
      q_data.motor_id  = req_payload.motor_id;
      q_data.value     = value_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (q_push) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         lat_proto_ff <= lat_proto_in;
         lat_dlen_ff  <= lat_dlen_in;
         lat_count_ff <= lat_count_in;
         lat_fmt_ff   <= lat_fmt_in;
      end
   end

   a_cnt_below_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 |-> cnt_ff < lat_count_ff)
      else $error("Entry count reached the packet size without closing.");

endmodule

// File: rtl/sbsw_fifo.sv
// ----------------------------------------------------------------------------
// Sync-write framer command queue
// Short queue of commands between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module sbsw_fifo
   import sbsw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  sbsw_cmd_type push_data,
   input  logic         pop,
   output logic         full,
   output logic         head_valid,
   output sbsw_cmd_type head_data
);

   sbsw_cmd_type           mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff;
   logic [CMD_CNT_W-1:0]   fill_ff;

   assign full       = (fill_ff == CMD_CNT_W'(CMD_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

// File: rtl/sbsw_back.sv
// ----------------------------------------------------------------------------
// Sync-write framer byte sequencer
// Walks header, ID, value and trailer bytes of the head command, keeps the
// running CRC or byte sum and drives the registered result channel.
// ----------------------------------------------------------------------------
module sbsw_back
   import sbsw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  sbsw_cmd_type head_data,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sbsw_rsp_type rsp_payload
);

   sbsw_phase_type   phase_ff, phase_in, phase_cur;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      check_ff, check_in;
   logic             rsp_valid_ff;
   sbsw_rsp_type     rsp_ff, rsp_in;
   logic             advance;
   logic             done;
   logic             upd;
   logic [15:0]      base;
   logic [IDX_W-1:0] hdr_last;

   assign advance  = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign hdr_last = head_data.proto ? HDR_LONG_LAST : HDR_SHORT_LAST;

   always_comb begin
      phase_cur = (phase_ff == PH_IDLE) ? (head_data.open_pkt ? PH_HDR : PH_ID) : phase_ff;
      phase_in  = phase_cur;
      idx_in    = idx_ff;
      done      = 1'b0;
      upd       = 1'b1;
      rsp_in    = '0;
      base      = (phase_cur == PH_HDR && idx_ff == '0) ? 16'd0 : check_ff;
      unique case (phase_cur)
         PH_HDR: begin
            rsp_in.out_byte = hdr_byte(head_data.proto, idx_ff, head_data.len,
                                       head_data.addr, head_data.dlen);
            if (idx_ff == hdr_last) begin
               phase_in = PH_ID;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         PH_ID: begin
            rsp_in.out_byte = head_data.motor_id;
            phase_in = PH_DATA;
            idx_in   = '0;
         end
         PH_DATA: begin
            rsp_in.out_byte = head_data.value[{idx_ff[1:0], 3'b000} +: 8];
            if (idx_ff == IDX_W'(head_data.dlen) - 1'b1) begin
               idx_in = '0;
               if (head_data.close_pkt) begin
                  phase_in = PH_TRL;
               end else begin
                  phase_in        = PH_IDLE;
                  done            = 1'b1;
                  rsp_in.run_last = 1'b1;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         PH_TRL: begin
            upd = 1'b0;
            if (!head_data.proto) begin
               rsp_in.out_byte = ~check_ff[7:0];
            end else if (idx_ff == '0) begin
               rsp_in.out_byte = check_ff[7:0];
            end else begin
               rsp_in.out_byte = check_ff[15:8];
            end
            if (!head_data.proto || idx_ff != '0) begin
               phase_in           = PH_IDLE;
               idx_in             = '0;
               done               = 1'b1;
               rsp_in.run_last    = 1'b1;
               rsp_in.packet_last = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            upd = 1'b0;
         end
      endcase
      if (!upd) begin
         check_in = check_ff;
      end else if (head_data.proto) begin
         check_in = crc_step(base, rsp_in.out_byte);
      end else if (phase_cur == PH_HDR && idx_ff < IDX_W'(2)) begin
         check_in = 16'd0;
      end else begin
         check_in = base + {8'h00, rsp_in.out_byte};
      end
   end

   assign pop = advance && done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= '0;
         check_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         check_ff <= check_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_trl_needs_close: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TRL |-> head_valid && head_data.close_pkt)
      else $error("Trailer phase without a closing command at the queue head.");

   a_hdr_needs_open: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HDR |-> head_valid && head_data.open_pkt)
      else $error("Header phase without an opening command at the queue head.");

   a_pkt_last_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.packet_last |-> rsp_ff.run_last)
      else $error("Packet end flagged on a beat that does not end its item.");

endmodule

// File: rtl/servo_bus_sync_write_framer.sv
// ----------------------------------------------------------------------------
// Servo bus sync-write framer
// Turns motor ID and value beats into the bytes of a broadcast sync-write
// packet, one byte per result beat.
// ----------------------------------------------------------------------------
// Each request beat yields one result beat per wire byte: the ID and one to
// four value bytes, plus the header (12 or 7 bytes) on the first entry of a
// packet and the CRC or checksum (2 or 1 bytes) on the last. The byte
// sequencer emits one byte per clock while the result channel is not stalled;
// a two-entry command queue lets the next request be taken while the current
// one is still being sent.
// Configuration is sampled when a packet opens.
module servo_bus_sync_write_framer
   import sbsw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  sbsw_req_type      req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sbsw_rsp_type      rsp_payload
);

   logic         q_full;
   logic         q_push;
   logic         q_pop;
   logic         head_valid;
   sbsw_cmd_type q_data;
   sbsw_cmd_type head_data;

   sbsw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   sbsw_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   sbsw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
